/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TSPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tspd checker: property failed");

// antecedent at one edge implies consequent at the next
`define TSPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tspd checker: property failed");

`endif

/* hw/rtl/tspd_pkg.sv */
// shared types and constants of the edge distance pipeline
package tspd_pkg;

  localparam int COORD_W    = 24;
  localparam int COORD_FRAC = 4;
  localparam int DIFF_W     = COORD_W;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int D_W        = SQ_W + 1;
  localparam int X_W        = D_W + 2;
  localparam int ROOT_STEPS = (X_W + 1) / 2;
  localparam int BIT_W      = 2 * ROOT_STEPS - 1;
  localparam int RES_W      = BIT_W + 1;
  localparam int SUM_W      = RES_W + 1;
  localparam int TRIAL_W    = SUM_W + 4;
  localparam int ROOT_W     = ROOT_STEPS + 1;
  localparam int W_W        = ROOT_W + 1;
  localparam int DIST_W     = 21;
  localparam int METRIC_W   = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [METRIC_W-1:0] METRIC_EUC_2D  = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_ATT     = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_CEIL_2D = 2'd2;

  typedef enum logic [1:0] {
    RULE_EUC,
    RULE_ATT,
    RULE_CEIL
  } rule_t;

  // one item inside the square root pipeline
  typedef struct packed {
    logic             valid;
    rule_t            rule;
    logic             zero;
    logic [X_W-1:0]   rem;
    logic [RES_W-1:0] res;
    logic [BIT_W-1:0] qbit;
  } root_item_t;

endpackage

/* hw/rtl/tsp_edge_distance.sv */
// top level: pipelined integer edge weight between two cities
//
// input channel: in_valid / in_stall with coordinates in_ax, in_ay, in_bx, in_by
// (signed fixed point, COORD_FRAC fraction bits); a beat moves when in_valid is
// high and in_stall is low
// result channel: out_valid / out_stall with out_distance, the rounded weight
// configuration: cfg_valid / cfg_ready / cfg_data writes the metric register
// (0 euc_2d nearest, 1 att, 2 ceil_2d, code 3 behaves as ceil_2d); cfg_ready
// is always high, and the register should only change while the pipe is empty
// throughput: one beat per cycle unless the pipe stalls; the depth comes from
// the 26 digit steps of the square root, one per register stage, after four
// stages of difference, square, sum and operand set-up, and before the output
// register
// stall: the whole pipe holds while out_valid is high and out_stall is high,
// and in_stall follows that same condition, so nothing is dropped or repeated
// reset: synchronous, active low; clears all valid bits and the metric
// register to euc_2d
module tsp_edge_distance import tspd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_ax,
  input  logic signed [COORD_W-1:0] in_ay,
  input  logic signed [COORD_W-1:0] in_bx,
  input  logic signed [COORD_W-1:0] in_by,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DIST_W-1:0]         out_distance,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [METRIC_W-1:0]       cfg_data
);

  // global advance: every stage moves unless a result sits unaccepted
  logic adv;

  logic [METRIC_W-1:0] metric_r;
  rule_t               rule_dec;

  // stage 1: absolute differences
  logic [COORD_W:0]  dx;
  logic [COORD_W:0]  dy;
  logic [COORD_W:0]  dx_abs;
  logic [COORD_W:0]  dy_abs;
  logic              s1_valid_r;
  logic [DIFF_W-1:0] s1_ux_r;
  logic [DIFF_W-1:0] s1_uy_r;

  // stage 2: squares
  logic            s2_valid_r;
  logic [SQ_W-1:0] s2_sqx_r;
  logic [SQ_W-1:0] s2_sqy_r;

  // stage 3: squared distance
  logic           s3_valid_r;
  logic [D_W-1:0] s3_d_r;
  rule_t          s3_rule_r;

  // stage 4: root operand set-up
  root_item_t s4_item_nxt;
  root_item_t s4_item_r;

  root_item_t chain [ROOT_STEPS+1];

  // output stage
  logic [ROOT_W-1:0] root;
  logic [W_W-1:0]    w_euc;
  logic [W_W-1:0]    w_sel;
  logic [DIST_W-1:0] dist_nxt;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_distance_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // metric register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= METRIC_EUC_2D;
    end else if (cfg_valid && cfg_ready) begin
      metric_r <= cfg_data;
    end
  end

  always_comb begin
    unique case (metric_r)
      METRIC_EUC_2D: rule_dec = RULE_EUC;
      METRIC_ATT:    rule_dec = RULE_ATT;
      default:       rule_dec = RULE_CEIL;
    endcase
  end

  // differences are one bit wider so the extremes cannot wrap
  always_comb begin
    dx     = {in_ax[COORD_W-1], in_ax} - {in_bx[COORD_W-1], in_bx};
    dy     = {in_ay[COORD_W-1], in_ay} - {in_by[COORD_W-1], in_by};
    dx_abs = dx[COORD_W] ? (~dx + 1'b1) : dx;
    dy_abs = dy[COORD_W] ? (~dy + 1'b1) : dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ux_r   <= dx_abs[DIFF_W-1:0];
      s1_uy_r   <= dy_abs[DIFF_W-1:0];
      s2_sqx_r  <= SQ_W'(s1_ux_r) * SQ_W'(s1_ux_r);
      s2_sqy_r  <= SQ_W'(s1_uy_r) * SQ_W'(s1_uy_r);
      s3_d_r    <= D_W'(s2_sqx_r) + D_W'(s2_sqy_r);
      s3_rule_r <= rule_dec;
    end
  end

  // euc_2d roots 4d directly; the ceiling rules root floor((d-1)/2^2f),
  // att with a factor of ten on the square, and add one at the end
  always_comb begin
    s4_item_nxt       = '0;
    s4_item_nxt.valid = s3_valid_r;
    s4_item_nxt.rule  = s3_rule_r;
    s4_item_nxt.zero  = (s3_d_r == '0);
    s4_item_nxt.qbit  = BIT_W'(1) << (BIT_W - 1);
    s4_item_nxt.res   = '0;
    if (s3_rule_r == RULE_EUC) begin
      s4_item_nxt.rem = X_W'(s3_d_r) << 2;
    end else if (s4_item_nxt.zero) begin
      s4_item_nxt.rem = '0;
    end else begin
      s4_item_nxt.rem = X_W'((s3_d_r - 1'b1) >> (2 * COORD_FRAC));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_item_r.valid <= 1'b0;
    end else if (adv) begin
      s4_item_r <= s4_item_nxt;
    end
  end

  // one root digit per stage
  assign chain[0] = s4_item_r;

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    tspd_root_stage u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  // final rounding and saturation
  always_comb begin
    root  = chain[ROOT_STEPS].res[ROOT_W-1:0];
    w_euc = (W_W'(root) + (W_W'(1) << COORD_FRAC)) >> (COORD_FRAC + 1);
    if (chain[ROOT_STEPS].rule == RULE_EUC) begin
      w_sel = w_euc;
    end else if (chain[ROOT_STEPS].zero) begin
      w_sel = '0;
    end else begin
      w_sel = W_W'(root) + 1'b1;
    end
    if (w_sel > W_W'(DIST_MAX)) begin
      dist_nxt = DIST_MAX;
    end else begin
      dist_nxt = w_sel[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[ROOT_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_distance_r <= dist_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

endmodule

/* hw/rtl/tspd_root_stage.sv */
// one registered digit step of the scaled integer square root
module tspd_root_stage import tspd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  root_item_t item_i,
  output root_item_t item_o
);

  logic [SUM_W-1:0]   sum;
  logic [TRIAL_W-1:0] trial;
  logic               fits;
  root_item_t         item_nxt;
  root_item_t         item_r;

  always_comb begin
    sum = SUM_W'(item_i.res) + SUM_W'(item_i.qbit);
    // att compares against ten times the square
    if (item_i.rule == RULE_ATT) begin
      trial = (TRIAL_W'(sum) << 3) + (TRIAL_W'(sum) << 1);
    end else begin
      trial = TRIAL_W'(sum);
    end
    fits = TRIAL_W'(item_i.rem) >= trial;

    item_nxt      = item_i;
    item_nxt.qbit = item_i.qbit >> 2;
    if (fits) begin
      item_nxt.rem = item_i.rem - X_W'(trial);
      item_nxt.res = (item_i.res >> 1) + RES_W'(item_i.qbit);
    end else begin
      item_nxt.res = item_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

/* hw/rtl/tspd_checker.sv */
// port level checker for the edge distance block and its bind
`include "assert_macros.svh"

module tspd_checker import tspd_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic signed [COORD_W-1:0] in_ax,
  input logic signed [COORD_W-1:0] in_ay,
  input logic signed [COORD_W-1:0] in_bx,
  input logic signed [COORD_W-1:0] in_by,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [DIST_W-1:0]         out_distance,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  // whole input beat as one vector
  logic [4*COORD_W-1:0] in_payload;

  assign in_payload = {in_ax, in_ay, in_bx, in_by};

  // a stalled result holds its value
  `TSPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_distance))

  // a stalled input beat holds its value
  `TSPD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_payload))

  // the input side only stalls behind a blocked result
  `TSPD_ASSERT(a_in_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall))

  // a result only leaves after a beat
  `TSPD_ASSERT(a_out_leave, clk, rst_n, ($fell(out_valid) && $past(rst_n)) |-> $past(!out_stall))

  // metric writes are never refused
  `TSPD_ASSERT(a_cfg_ready, clk, rst_n, cfg_valid |-> cfg_ready)

endmodule

bind tsp_edge_distance tspd_checker u_tspd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_ax        (in_ax),
  .in_ay        (in_ay),
  .in_bx        (in_bx),
  .in_by        (in_by),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_distance (out_distance),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
